// ===== src/lla_pkg.sv =====
// -----------------------------------------------------------------------------
// lla_pkg
// shared widths, codes and types of the lane line averager
// -----------------------------------------------------------------------------
package lla_pkg;

   // coordinate and fixed point format
   localparam int COORD_BITS   = 12;
   localparam int FRAC_BITS    = 16;
   localparam int MAX_SEGMENTS = 256;

   // accumulator widths
   localparam int CNT_W       = 9;
   localparam int SLOPE_SUM_W = 40;
   localparam int ICPT_SUM_W  = 52;

   // per segment slope, two's complement, a sign bit plus the bits of |dy| * 2^frac / |dx|
   localparam int SLOPE_STEPS = COORD_BITS + FRAC_BITS;
   localparam int SLOPE_W     = SLOPE_STEPS + 1;

   // shared serial divider
   localparam int DIV_W  = 52;
   localparam int DVS_W  = 40;
   localparam int STEP_W = 6;
   localparam int NUM_W  = DIV_W + 1;

   // multiplier step counter
   localparam int MCNT_W = $clog2(COORD_BITS + 1);

   // configuration registers
   localparam int ROW_W      = 13;
   localparam int TOP_W      = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = ROW_W;

   localparam logic [CSR_IDX_W-1:0] CSR_BOTTOM_ROW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_ROW    = 2'd1;

   localparam logic [ROW_W-1:0] BOTTOM_ROW_RESET = 13'd720;
   localparam logic [TOP_W-1:0] TOP_ROW_RESET    = 12'd432;

   // result format
   localparam int OUT_W    = 16;
   localparam int STATUS_W = 2;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_SLOPE = 2'd2;

   localparam logic SIDE_LEFT  = 1'b0;
   localparam logic SIDE_RIGHT = 1'b1;

   // divider request: dividend magnitude left aligned so that its top
   // steps bits are consumed, one quotient bit per step
   typedef struct packed {
      logic [DIV_W-1:0]  dividend;
      logic [DVS_W-1:0]  divisor;
      logic [STEP_W-1:0] steps;
   } div_req_type;

endpackage

// ===== src/lla_divider.sv =====
// -----------------------------------------------------------------------------
// lla_divider
// restoring unsigned divider, one quotient bit per clock cycle
// -----------------------------------------------------------------------------
module lla_divider import lla_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  div_req_type       req,
   output logic              done,
   output logic [DIV_W-1:0]  quotient
);

   logic              run_ff,  run_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff,  cnt_in;
   logic [DVS_W-1:0]  rem_ff,  rem_in;
   logic [DVS_W-1:0]  dvs_ff,  dvs_in;
   logic [DIV_W-1:0]  quo_ff,  quo_in;

   logic [DVS_W:0] trial;
   logic [DVS_W:0] diff;
   logic           fits;

   always_comb begin
      trial = {rem_ff, quo_ff[DIV_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = (trial >= {1'b0, dvs_ff});

      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;

      if (start) begin
         run_in = 1'b1;
         cnt_in = req.steps;
         rem_in = '0;
         dvs_in = req.divisor;
         quo_in = req.dividend;
      end else if (run_ff) begin
         rem_in = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== src/lane_line_averager_core.sv =====
// -----------------------------------------------------------------------------
// lane_line_averager_core
// averages the line segments of a frame into a left and a right lane line
// -----------------------------------------------------------------------------
//
//  channel   ports                      transfer
//  --------  -------------------------  ------------------------------------
//  request   start, busy, req_*         start high while busy low
//  response  rsp_valid, rsp_*           every cycle rsp_valid is high
//  csr       csr_valid, csr_ready,      csr_valid and csr_ready high
//            csr_index, csr_wdata
//
// a segment with a nonzero dx keeps busy high after its transfer while the
// serial divider works out its slope, then while the shift-add multiply
// forms its intercept and then while it is accumulated into its side
// the last item of a frame then adds, per side: up to four passes through
// the same divider (average slope, average intercept, x at the bottom row
// and x at the top row), the setup states and the response cycle
// busy stays high until the right lane result has gone out
// reset clears the sums, counts and state and loads the default rows
// responses cannot be held off, so the block never stalls on its output
//
module lane_line_averager_core import lla_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,

   // request channel
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_carries_segment,
   input  logic [COORD_BITS-1:0]        req_start_x,
   input  logic [COORD_BITS-1:0]        req_start_y,
   input  logic [COORD_BITS-1:0]        req_end_x,
   input  logic [COORD_BITS-1:0]        req_end_y,
   input  logic                         req_last_segment,

   // response channel
   output logic                         rsp_valid,
   output logic                         rsp_lane_side,
   output logic signed [OUT_W-1:0]      rsp_x_bottom,
   output logic signed [OUT_W-1:0]      rsp_x_top,
   output logic [STATUS_W-1:0]          rsp_status,
   output logic                         rsp_last_result,

   // register write channel
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   // state codes
   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] ST_IDLE      = 4'd0;
   localparam logic [ST_W-1:0] ST_SEG_DIV   = 4'd1;  // slope division
   localparam logic [ST_W-1:0] ST_SEG_MUL   = 4'd2;  // intercept shift-add
   localparam logic [ST_W-1:0] ST_SEG_ADD   = 4'd3;  // accumulate into side
   localparam logic [ST_W-1:0] ST_AVG_START = 4'd4;  // launch average slope
   localparam logic [ST_W-1:0] ST_AVG_M     = 4'd5;  // wait average slope
   localparam logic [ST_W-1:0] ST_AVG_B     = 4'd6;  // wait average intercept
   localparam logic [ST_W-1:0] ST_X_NUM     = 4'd7;  // row numerator
   localparam logic [ST_W-1:0] ST_X_GO      = 4'd8;  // launch x division
   localparam logic [ST_W-1:0] ST_X_DIV     = 4'd9;  // wait x division
   localparam logic [ST_W-1:0] ST_EMIT      = 4'd10; // one response cycle

   // control
   logic [ST_W-1:0] state_ff, state_in;
   logic            sd_ff,    sd_in;     // side being averaged
   logic            xsel_ff,  xsel_in;   // 0 bottom row, 1 top row

   // configuration
   logic [ROW_W-1:0] bottom_row_ff, bottom_row_in;
   logic [TOP_W-1:0] top_row_ff,    top_row_in;

   // side accumulators
   logic [SLOPE_SUM_W-1:0] left_slope_sum_ff,  left_slope_sum_in;
   logic [ICPT_SUM_W-1:0]  left_icpt_sum_ff,   left_icpt_sum_in;
   logic [CNT_W-1:0]       left_count_ff,      left_count_in;
   logic [SLOPE_SUM_W-1:0] right_slope_sum_ff, right_slope_sum_in;
   logic [ICPT_SUM_W-1:0]  right_icpt_sum_ff,  right_icpt_sum_in;
   logic [CNT_W-1:0]       right_count_ff,     right_count_in;

   // segment datapath
   logic                  last_ff,   last_in;
   logic                  side_ff,   side_in;
   logic                  neg_ff,    neg_in;
   logic [COORD_BITS-1:0] y1_ff,     y1_in;
   logic [COORD_BITS-1:0] mbits_ff,  mbits_in;   // multiplier bits, lsb first
   logic [MCNT_W-1:0]     mcnt_ff,   mcnt_in;
   logic [SLOPE_W-1:0]    slope_ff,  slope_in;
   logic [ICPT_SUM_W-1:0] mcand_ff,  mcand_in;
   logic [ICPT_SUM_W-1:0] acc_ff,    acc_in;

   // averaging datapath
   logic [DVS_W-1:0]    m_mag_ff, m_mag_in;
   logic                m_neg_ff, m_neg_in;
   logic [NUM_W-1:0]    b_ff,     b_in;
   logic [NUM_W-1:0]    num_ff,   num_in;
   logic                xneg_ff,  xneg_in;

   // response payload
   logic [OUT_W-1:0]    xb_ff,     xb_in;
   logic [OUT_W-1:0]    xt_ff,     xt_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   // divider
   logic              div_start;
   div_req_type       div_req;
   logic              div_done;
   logic [DIV_W-1:0]  div_quo;

   // combinational helpers
   logic                       accept;
   logic signed [COORD_BITS:0] dx;
   logic signed [COORD_BITS:0] dy;
   logic [COORD_BITS:0]        dx_neg_full;
   logic [COORD_BITS:0]        dy_neg_full;
   logic [COORD_BITS-1:0]      dx_mag;
   logic [COORD_BITS-1:0]      dy_mag;

   logic [CNT_W-1:0]       cnt_sel;
   logic [SLOPE_SUM_W-1:0] ssum_sel;
   logic [ICPT_SUM_W-1:0]  isum_sel;
   logic [SLOPE_SUM_W-1:0] ssum_mag;
   logic [ICPT_SUM_W-1:0]  isum_mag;
   logic [NUM_W-1:0]       num_neg_full;
   logic [DIV_W-1:0]       num_mag;
   logic [CNT_W-1:0]       tgt_count;

   logic [SLOPE_W-1:0]     slope_mag;
   logic [SLOPE_W-1:0]     slope_val;
   logic [NUM_W-1:0]       b_mag;
   logic [NUM_W-1:0]       row_fix;
   logic [OUT_W-1:0]       x_sat;
   logic [SLOPE_SUM_W-1:0] slope_ext;

   // saturate a sign-magnitude quotient to the signed output range
   function automatic logic [OUT_W-1:0] sat_out(input logic [DIV_W-1:0] mag,
                                                input logic neg);
      logic [OUT_W-1:0] res;
      if (neg) begin
         if (mag > DIV_W'(32768)) res = 16'h8000;
         else                     res = OUT_W'(-mag);
      end else begin
         if (mag > DIV_W'(32767)) res = 16'h7fff;
         else                     res = mag[OUT_W-1:0];
      end
      return res;
   endfunction

   lla_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // segment deltas straight from the request ports
   assign dx          = $signed({1'b0, req_end_x}) - $signed({1'b0, req_start_x});
   assign dy          = $signed({1'b0, req_end_y}) - $signed({1'b0, req_start_y});
   assign dx_neg_full = -dx;
   assign dy_neg_full = -dy;
   assign dx_mag      = dx[COORD_BITS] ? dx_neg_full[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
   assign dy_mag      = dy[COORD_BITS] ? dy_neg_full[COORD_BITS-1:0] : dy[COORD_BITS-1:0];

   // side selected for averaging
   assign cnt_sel  = sd_ff ? right_count_ff     : left_count_ff;
   assign ssum_sel = sd_ff ? right_slope_sum_ff : left_slope_sum_ff;
   assign isum_sel = sd_ff ? right_icpt_sum_ff  : left_icpt_sum_ff;
   assign ssum_mag = ssum_sel[SLOPE_SUM_W-1] ? -ssum_sel : ssum_sel;
   assign isum_mag = isum_sel[ICPT_SUM_W-1]  ? -isum_sel : isum_sel;

   assign num_neg_full = -num_ff;
   assign num_mag      = num_ff[NUM_W-1] ? num_neg_full[DIV_W-1:0] : num_ff[DIV_W-1:0];

   // side a segment goes to
   assign tgt_count = side_ff ? right_count_ff : left_count_ff;

   assign slope_mag = {1'b0, div_quo[SLOPE_STEPS-1:0]};
   assign slope_val = neg_ff ? -slope_mag : slope_mag;
   assign slope_ext = {{(SLOPE_SUM_W-SLOPE_W){slope_ff[SLOPE_W-1]}}, slope_ff};
   assign b_mag     = {1'b0, div_quo};
   assign row_fix   = xsel_ff ? NUM_W'({top_row_ff, {FRAC_BITS{1'b0}}})
                              : NUM_W'({bottom_row_ff, {FRAC_BITS{1'b0}}});
   assign x_sat     = sat_out(div_quo, xneg_ff);

   // divider launches, each with its dividend left aligned to its step count
   always_comb begin
      div_start = 1'b0;
      div_req   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_carries_segment && (dx != '0)) begin
               div_start        = 1'b1;
               div_req.dividend = DIV_W'(dy_mag) << (DIV_W - COORD_BITS);
               div_req.divisor  = DVS_W'(dx_mag);
               div_req.steps    = STEP_W'(SLOPE_STEPS);
            end
         end
         ST_AVG_START: begin
            if (cnt_sel != '0) begin
               div_start        = 1'b1;
               div_req.dividend = DIV_W'(ssum_mag) << (DIV_W - SLOPE_SUM_W);
               div_req.divisor  = DVS_W'(cnt_sel);
               div_req.steps    = STEP_W'(SLOPE_SUM_W);
            end
         end
         ST_AVG_M: begin
            if (div_done && (div_quo != '0)) begin
               div_start        = 1'b1;
               div_req.dividend = DIV_W'(isum_mag);
               div_req.divisor  = DVS_W'(cnt_sel);
               div_req.steps    = STEP_W'(ICPT_SUM_W);
            end
         end
         ST_X_GO: begin
            div_start        = 1'b1;
            div_req.dividend = num_mag;
            div_req.divisor  = m_mag_ff;
            div_req.steps    = STEP_W'(DIV_W);
         end
         default: begin
         end
      endcase
   end

   // next state and datapath
   always_comb begin
      state_in           = state_ff;
      sd_in              = sd_ff;
      xsel_in            = xsel_ff;
      bottom_row_in      = bottom_row_ff;
      top_row_in         = top_row_ff;
      left_slope_sum_in  = left_slope_sum_ff;
      left_icpt_sum_in   = left_icpt_sum_ff;
      left_count_in      = left_count_ff;
      right_slope_sum_in = right_slope_sum_ff;
      right_icpt_sum_in  = right_icpt_sum_ff;
      right_count_in     = right_count_ff;
      last_in            = last_ff;
      side_in            = side_ff;
      neg_in             = neg_ff;
      y1_in              = y1_ff;
      mbits_in           = mbits_ff;
      mcnt_in            = mcnt_ff;
      slope_in           = slope_ff;
      mcand_in           = mcand_ff;
      acc_in             = acc_ff;
      m_mag_in           = m_mag_ff;
      m_neg_in           = m_neg_ff;
      b_in               = b_ff;
      num_in             = num_ff;
      xneg_in            = xneg_ff;
      xb_in              = xb_ff;
      xt_in              = xt_ff;
      status_in          = status_ff;

      // register writes must arrive only while idle, the block itself does not enforce it
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BOTTOM_ROW: bottom_row_in = csr_wdata[ROW_W-1:0];
            CSR_TOP_ROW:    top_row_in    = csr_wdata[TOP_W-1:0];
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_in  = req_last_segment;
               // left only when dy is nonzero and the sign bits of dy and dx differ
               side_in  = (dy != '0) && (dy[COORD_BITS] == dx[COORD_BITS])
                          ? SIDE_RIGHT
                          : ((dy == '0) ? SIDE_RIGHT : SIDE_LEFT);
               neg_in   = dy[COORD_BITS] ^ dx[COORD_BITS];
               y1_in    = req_start_y;
               mbits_in = req_start_x;
               sd_in    = SIDE_LEFT;
               priority if (req_carries_segment && (dx != '0)) begin
                  state_in = ST_SEG_DIV;
               end else if (req_last_segment) begin
                  // vertical or empty item closing the frame
                  state_in = ST_AVG_START;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_SEG_DIV: begin
            if (div_done) begin
               slope_in = slope_val;
               mcand_in = {{(ICPT_SUM_W-SLOPE_W){slope_val[SLOPE_W-1]}}, slope_val};
               acc_in   = ICPT_SUM_W'({y1_ff, {FRAC_BITS{1'b0}}});
               mcnt_in  = MCNT_W'(COORD_BITS);
               state_in = ST_SEG_MUL;
            end
         end

         // intercept = y1 * 2^frac - slope * x1, one bit of x1 per cycle
         ST_SEG_MUL: begin
            if (mbits_ff[0]) begin
               acc_in = acc_ff - mcand_ff;
            end
            mcand_in = {mcand_ff[ICPT_SUM_W-2:0], 1'b0};
            mbits_in = {1'b0, mbits_ff[COORD_BITS-1:1]};
            mcnt_in  = mcnt_ff - 1'b1;
            if (mcnt_ff == MCNT_W'(1)) begin
               state_in = ST_SEG_ADD;
            end
         end

         ST_SEG_ADD: begin
            // a full side ignores further segments
            if (tgt_count < CNT_W'(MAX_SEGMENTS)) begin
               if (side_ff == SIDE_RIGHT) begin
                  right_slope_sum_in = right_slope_sum_ff + slope_ext;
                  right_icpt_sum_in  = right_icpt_sum_ff + acc_ff;
                  right_count_in     = right_count_ff + 1'b1;
               end else begin
                  left_slope_sum_in  = left_slope_sum_ff + slope_ext;
                  left_icpt_sum_in   = left_icpt_sum_ff + acc_ff;
                  left_count_in      = left_count_ff + 1'b1;
               end
            end
            state_in = last_ff ? ST_AVG_START : ST_IDLE;
         end

         ST_AVG_START: begin
            if (cnt_sel == '0) begin
               status_in = STATUS_EMPTY;
               xb_in     = '0;
               xt_in     = '0;
               state_in  = ST_EMIT;
            end else begin
               state_in  = ST_AVG_M;
            end
         end

         ST_AVG_M: begin
            if (div_done) begin
               m_mag_in = div_quo[DVS_W-1:0];
               m_neg_in = ssum_sel[SLOPE_SUM_W-1];
               if (div_quo == '0) begin
                  status_in = STATUS_ZERO_SLOPE;
                  xb_in     = '0;
                  xt_in     = '0;
                  state_in  = ST_EMIT;
               end else begin
                  state_in  = ST_AVG_B;
               end
            end
         end

         ST_AVG_B: begin
            if (div_done) begin
               b_in     = isum_sel[ICPT_SUM_W-1] ? -b_mag : b_mag;
               xsel_in  = 1'b0;
               state_in = ST_X_NUM;
            end
         end

         ST_X_NUM: begin
            num_in   = row_fix - b_ff;
            state_in = ST_X_GO;
         end

         ST_X_GO: begin
            xneg_in  = num_ff[NUM_W-1] ^ m_neg_ff;
            state_in = ST_X_DIV;
         end

         ST_X_DIV: begin
            if (div_done) begin
               if (xsel_ff) begin
                  xt_in     = x_sat;
                  status_in = STATUS_OK;
                  state_in  = ST_EMIT;
               end else begin
                  xb_in     = x_sat;
                  xsel_in   = 1'b1;
                  state_in  = ST_X_NUM;
               end
            end
         end

         ST_EMIT: begin
            if (sd_ff == SIDE_LEFT) begin
               sd_in    = SIDE_RIGHT;
               state_in = ST_AVG_START;
            end else begin
               // frame done, sums start over
               left_slope_sum_in  = '0;
               left_icpt_sum_in   = '0;
               left_count_in      = '0;
               right_slope_sum_in = '0;
               right_icpt_sum_in  = '0;
               right_count_in     = '0;
               state_in           = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         sd_ff              <= SIDE_LEFT;
         xsel_ff            <= 1'b0;
         bottom_row_ff      <= BOTTOM_ROW_RESET;
         top_row_ff         <= TOP_ROW_RESET;
         left_slope_sum_ff  <= '0;
         left_icpt_sum_ff   <= '0;
         left_count_ff      <= '0;
         right_slope_sum_ff <= '0;
         right_icpt_sum_ff  <= '0;
         right_count_ff     <= '0;
         last_ff            <= 1'b0;
         mcnt_ff            <= '0;
      end else begin
         state_ff           <= state_in;
         sd_ff              <= sd_in;
         xsel_ff            <= xsel_in;
         bottom_row_ff      <= bottom_row_in;
         top_row_ff         <= top_row_in;
         left_slope_sum_ff  <= left_slope_sum_in;
         left_icpt_sum_ff   <= left_icpt_sum_in;
         left_count_ff      <= left_count_in;
         right_slope_sum_ff <= right_slope_sum_in;
         right_icpt_sum_ff  <= right_icpt_sum_in;
         right_count_ff     <= right_count_in;
         last_ff            <= last_in;
         mcnt_ff            <= mcnt_in;
      end
      side_ff   <= side_in;
      neg_ff    <= neg_in;
      y1_ff     <= y1_in;
      mbits_ff  <= mbits_in;
      slope_ff  <= slope_in;
      mcand_ff  <= mcand_in;
      acc_ff    <= acc_in;
      m_mag_ff  <= m_mag_in;
      m_neg_ff  <= m_neg_in;
      b_ff      <= b_in;
      num_ff    <= num_in;
      xneg_ff   <= xneg_in;
      xb_ff     <= xb_in;
      xt_ff     <= xt_in;
      status_ff <= status_in;
   end

   // response, one cycle per side, left first
   assign rsp_valid       = (state_ff == ST_EMIT);
   assign rsp_lane_side   = sd_ff;
   assign rsp_x_bottom    = xb_ff;
   assign rsp_x_top       = xt_ff;
   assign rsp_status      = status_ff;
   assign rsp_last_result = sd_ff;

endmodule

// ===== verif/lane_line_averager_core_tb.sv =====
// -----------------------------------------------------------------------------
// lane_line_averager_core_tb
// self-checking bench: segment frames in, averaged left and right lane lines out
// -----------------------------------------------------------------------------
//
// frames of line segments go in through the start/busy channel, and every
// accepted transfer is fed into a fixed point model of the averager held in a
// small scoreboard class. the model keeps its own side sums and row registers
// and queues the two lane lines each frame end must produce. every response
// strobe is checked field by field against the oldest queued lane line.
//
module lane_line_averager_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lla_pkg::*;

   localparam int CLK_HALF      = 6;
   localparam int RESET_CYCLES  = 4;
   localparam int SETTLE_CYCLES = 64;         // longer than one segment's work
   localparam int CYCLE_LIMIT   = 5_000_000;
   localparam int OVERFLOW_SEGS = 262;        // past the per side segment cap

   // index that selects no register
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct {
      bit                  carries;
      bit [COORD_BITS-1:0] sx;
      bit [COORD_BITS-1:0] sy;
      bit [COORD_BITS-1:0] ex;
      bit [COORD_BITS-1:0] ey;
      bit                  last;
   } segment_item_type;

   typedef struct {
      logic                    lane_side;
      logic signed [OUT_W-1:0] x_bottom;
      logic signed [OUT_W-1:0] x_top;
      logic [STATUS_W-1:0]     status;
      logic                    last_result;
   } lane_result_type;

   // --------------------------------------------------------------------------
   // lane line model and result store
   // --------------------------------------------------------------------------
   class lane_scoreboard;
      logic [ROW_W-1:0]       bottom_row;
      logic [TOP_W-1:0]       top_row;
      logic [SLOPE_SUM_W-1:0] slope_sum [2];
      logic [ICPT_SUM_W-1:0]  icpt_sum [2];
      int unsigned            seg_count [2];
      lane_result_type        lane_q [$];
      int                     errors;

      function new();
         bottom_row = BOTTOM_ROW_RESET;
         top_row    = TOP_ROW_RESET;
         errors     = 0;
         clear_sums();
      endfunction

      function void clear_sums();
         for (int s = 0; s < 2; s++) begin
            slope_sum[s] = '0;
            icpt_sum[s]  = '0;
            seg_count[s] = 0;
         end
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_BOTTOM_ROW: bottom_row = data;
            CSR_TOP_ROW:    top_row = data[TOP_W-1:0];
            default: ;
         endcase
      endfunction

      function void accumulate_segment(segment_item_type it);
         longint x1, y1, x2, y2, dx, dy, slope, icpt;
         int     s;
         x1 = longint'(it.sx);
         y1 = longint'(it.sy);
         x2 = longint'(it.ex);
         y2 = longint'(it.ey);
         dx = x2 - x1;
         dy = y2 - y1;
         // vertical segments carry no slope
         if (dx == 0)
            return;
         slope = (dy <<< FRAC_BITS) / dx;
         icpt  = (y1 <<< FRAC_BITS) - slope * x1;
         // left only when the deltas have opposite signs, horizontal goes right
         s = (dy != 0 && ((dy < 0) != (dx < 0))) ? SIDE_LEFT : SIDE_RIGHT;
         if (seg_count[s] >= MAX_SEGMENTS)
            return;
         slope_sum[s] = slope_sum[s] + SLOPE_SUM_W'(slope);
         icpt_sum[s]  = icpt_sum[s] + ICPT_SUM_W'(icpt);
         seg_count[s]++;
      endfunction

      function longint lane_x_at_row(logic [ROW_W-1:0] row, longint m, longint b);
         longint x;
         x = ((longint'(row) <<< FRAC_BITS) - b) / m;
         if (x > 32767)
            x = 32767;
         if (x < -32768)
            x = -32768;
         return x;
      endfunction

      function lane_result_type average_lane(int s);
         lane_result_type r;
         longint          m, b, n;
         r.lane_side   = (s == SIDE_RIGHT);
         r.last_result = (s == SIDE_RIGHT);
         r.x_bottom    = '0;
         r.x_top       = '0;
         r.status      = STATUS_OK;
         if (seg_count[s] == 0) begin
            r.status = STATUS_EMPTY;
            return r;
         end
         n = longint'(seg_count[s]);
         m = longint'($signed(slope_sum[s]));
         b = longint'($signed(icpt_sum[s]));
         m = m / n;
         b = b / n;
         if (m == 0) begin
            r.status = STATUS_ZERO_SLOPE;
            return r;
         end
         r.x_bottom = OUT_W'(lane_x_at_row(bottom_row, m, b));
         r.x_top    = OUT_W'(lane_x_at_row(ROW_W'(top_row), m, b));
         return r;
      endfunction

      // one accepted request transfer
      function void note_request(segment_item_type it);
         if (it.carries)
            accumulate_segment(it);
         if (it.last) begin
            lane_q = {lane_q, average_lane(SIDE_LEFT)};
            lane_q = {lane_q, average_lane(SIDE_RIGHT)};
            clear_sums();
         end
      endfunction

      function void compare_field(string name, logic signed [63:0] want,
                                  logic signed [63:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      // one response transfer
      function void check_result(lane_result_type got);
         lane_result_type want;
         if (lane_q.size() == 0) begin
            $display("%0t: lane line with no expectation, expected none actual side %0d",
                     $time, got.lane_side);
            errors++;
            return;
         end
         want = lane_q.pop_front();
         compare_field("lane_side", want.lane_side, got.lane_side);
         compare_field("x_bottom", want.x_bottom, got.x_bottom);
         compare_field("x_top", want.x_top, got.x_top);
         compare_field("status", want.status, got.status);
         compare_field("last_result", want.last_result, got.last_result);
      endfunction
   endclass

   // --------------------------------------------------------------------------
   // block hookup
   // --------------------------------------------------------------------------
   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic                    req_carries_segment = 1'b0;
   logic [COORD_BITS-1:0]   req_start_x = '0;
   logic [COORD_BITS-1:0]   req_start_y = '0;
   logic [COORD_BITS-1:0]   req_end_x = '0;
   logic [COORD_BITS-1:0]   req_end_y = '0;
   logic                    req_last_segment = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_lane_side;
   logic signed [OUT_W-1:0] rsp_x_bottom;
   logic signed [OUT_W-1:0] rsp_x_top;
   logic [STATUS_W-1:0]     rsp_status;
   logic                    rsp_last_result;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   lane_scoreboard lane_sb = new();
   int unsigned    cycle_count = 0;

   lane_line_averager_core i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_carries_segment (req_carries_segment),
      .req_start_x         (req_start_x),
      .req_start_y         (req_start_y),
      .req_end_x           (req_end_x),
      .req_end_y           (req_end_y),
      .req_last_segment    (req_last_segment),
      .rsp_valid           (rsp_valid),
      .rsp_lane_side       (rsp_lane_side),
      .rsp_x_bottom        (rsp_x_bottom),
      .rsp_x_top           (rsp_x_top),
      .rsp_status          (rsp_status),
      .rsp_last_result     (rsp_last_result),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      forever #(CLK_HALF) clock = ~clock;
   end

   // responses cannot be held off, every strobe is a transfer
   always @(posedge clock) begin : watch_lanes
      lane_result_type got;
      if (!reset && rsp_valid) begin
         got.lane_side   = rsp_lane_side;
         got.x_bottom    = rsp_x_bottom;
         got.x_top       = rsp_x_top;
         got.status      = rsp_status;
         got.last_result = rsp_last_result;
         lane_sb.check_result(got);
      end
   end

   // hang guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // stimulus helpers
   // --------------------------------------------------------------------------
   function automatic segment_item_type seg(bit c, int sx, int sy, int ex, int ey, bit l);
      segment_item_type it;
      it.carries = c;
      it.sx      = COORD_BITS'(sx);
      it.sy      = COORD_BITS'(sy);
      it.ex      = COORD_BITS'(ex);
      it.ey      = COORD_BITS'(ey);
      it.last    = l;
      return it;
   endfunction

   // coordinates lean on the edges of the range now and then
   function automatic logic [COORD_BITS-1:0] pick_coord();
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return '1;
         2:       return COORD_BITS'($urandom_range(0, 15));
         3:       return COORD_BITS'(4095 - $urandom_range(0, 15));
         default: return COORD_BITS'($urandom);
      endcase
   endfunction

   function automatic segment_item_type random_segment();
      segment_item_type it;
      it = seg(1'b1, pick_coord(), pick_coord(), pick_coord(), pick_coord(), 1'b0);
      // vertical and horizontal segments show up regularly
      case ($urandom_range(0, 11))
         0:       it.ex = it.sx;
         1:       it.ey = it.sy;
         default: ;
      endcase
      return it;
   endfunction

   // idle cycles before the next request, with an occasional long gap so that
   // start rises at every point of the block's work
   function automatic int draw_gap(int idle_pct);
      int g;
      g = 0;
      if (idle_pct == 0)
         return 0;
      if ($urandom_range(0, 19) == 0)
         return $urandom_range(1, 450);
      while (g < 32 && $urandom_range(0, 99) < idle_pct)
         g++;
      return g;
   endfunction

   // start stays high across back to back requests, this task lowers it only for a gap
   task automatic send_segment(segment_item_type it, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start               <= 1'b1;
      req_carries_segment <= it.carries;
      req_start_x         <= it.sx;
      req_start_y         <= it.sy;
      req_end_x           <= it.ex;
      req_end_y           <= it.ey;
      req_last_segment    <= it.last;
      do @(posedge clock); while (busy !== 1'b0);
      lane_sb.note_request(it);
   endtask

   // sender holds off until every queued lane line has come out
   task automatic hold_for_lanes();
      start <= 1'b0;
      do @(posedge clock); while (lane_sb.lane_q.size() != 0);
   endtask

   // full quiet point: nothing owed, block idle, a trailing segment finished
   task automatic drain_lanes();
      start <= 1'b0;
      do @(posedge clock); while (lane_sb.lane_q.size() != 0 || busy !== 1'b0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // valid stays high across back to back writes, caller lowers it
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      lane_sb.write_reg(idx, data);
   endtask

   task automatic run_directed(int idle_pct);
      // frame end alone, both sides empty
      send_segment(seg(1'b0, 0, 0, 0, 0, 1'b1), draw_gap(idle_pct));
      // neither segment nor frame end, ignored
      send_segment(seg(1'b0, 4095, 4095, 4095, 4095, 1'b0), draw_gap(idle_pct));
      // diagonal left, diagonal right, vertical, both deltas negative, horizontal on last
      send_segment(seg(1'b1, 0, 4095, 4095, 0, 1'b0), draw_gap(idle_pct));
      send_segment(seg(1'b1, 0, 0, 4095, 4095, 1'b0), draw_gap(idle_pct));
      send_segment(seg(1'b1, 100, 10, 100, 900, 1'b0), draw_gap(idle_pct));
      send_segment(seg(1'b1, 4095, 4095, 0, 0, 1'b0), draw_gap(idle_pct));
      send_segment(seg(1'b1, 0, 4095, 4095, 4095, 1'b1), draw_gap(idle_pct));
      // horizontal only: left empty, right averages to a flat line
      send_segment(seg(1'b1, 10, 2000, 4000, 2000, 1'b1), draw_gap(idle_pct));
      // shallowest slopes push x past both saturation limits
      send_segment(seg(1'b1, 0, 0, 4095, 1, 1'b0), draw_gap(idle_pct));
      send_segment(seg(1'b1, 0, 1, 4095, 0, 1'b1), draw_gap(idle_pct));
      // left with dx negative, then a vertical segment on the frame end
      send_segment(seg(1'b1, 4095, 0, 0, 4095, 1'b0), draw_gap(idle_pct));
      send_segment(seg(1'b1, 2000, 3000, 2000, 10, 1'b1), draw_gap(idle_pct));
      // a plain single segment frame
      send_segment(seg(1'b1, 1234, 567, 2345, 3456, 1'b1), draw_gap(idle_pct));
   endtask

   // one frame with more left segments than the count can take
   task automatic overflow_frame(int idle_pct);
      segment_item_type it;
      int               sx, sy;
      for (int k = 0; k < OVERFLOW_SEGS + 4; k++) begin
         sx = $urandom_range(0, 2047);
         sy = $urandom_range(2048, 4095);
         if (k < OVERFLOW_SEGS || k == OVERFLOW_SEGS + 3)
            it = seg(1'b1, sx, sy, sx + $urandom_range(1, 2048), sy - $urandom_range(1, 2048),
                     k == OVERFLOW_SEGS + 3);
         else
            it = random_segment();
         send_segment(it, draw_gap(idle_pct));
      end
   endtask

   // mostly well formed frames with random content, some ignored items between
   task automatic random_frames(int items_wanted, int idle_pct);
      segment_item_type it;
      int               sent, n;
      sent = 0;
      while (sent < items_wanted) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 6);
         for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 14) == 0) begin
               it         = random_segment();
               it.carries = 1'b0;
               send_segment(it, draw_gap(idle_pct));
            end
            send_segment(random_segment(), draw_gap(idle_pct));
            sent++;
         end
         it         = random_segment();
         it.carries = 1'($urandom_range(0, 1));
         it.last    = 1'b1;
         send_segment(it, draw_gap(idle_pct));
         sent++;
         if ($urandom_range(0, 9) == 0)
            hold_for_lanes();
      end
   endtask

   // --------------------------------------------------------------------------
   // test sequence
   // --------------------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset rows first
      run_directed(13);

      // rows at their extremes, sender idles lightly
      drain_lanes();
      write_csr(CSR_BOTTOM_ROW, 13'd4096);
      write_csr(CSR_TOP_ROW, 13'd0);
      csr_valid <= 1'b0;
      run_directed(13);
      overflow_frame(13);
      random_frames(250, 13);

      // the other extremes plus a write that selects nothing, sender idles a lot
      drain_lanes();
      write_csr(CSR_BOTTOM_ROW, 13'd1);
      write_csr(CSR_TOP_ROW, 13'd4095);
      write_csr(CSR_SPARE, CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
      run_directed(60);
      random_frames(250, 60);

      // random rows, top row data with its unused upper bit random, no idling
      drain_lanes();
      write_csr(CSR_BOTTOM_ROW, CSR_DATA_W'($urandom_range(1, 4096)));
      write_csr(CSR_TOP_ROW, CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
      random_frames(250, 0);

      drain_lanes();
      if (lane_sb.errors == 0 && lane_sb.lane_q.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
